// File: rtl/core/lhs_pkg.sv
// Shared types and constants for the lookahead heading steer block.
package lhs_pkg;

   localparam int COORD_W = 24;
   localparam int DIST_W  = 49;
   localparam int ZW      = 34;
   localparam int CW      = 33;
   localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [18:0] PI_Q13     = 19'sd25736;
   localparam logic signed [18:0] TWO_PI_Q13 = 19'sd51472;
   localparam int unsigned ADDR_LOOKAHEAD = 0;
   localparam int unsigned ADDR_GAIN      = 1;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SETUP  = 6'b000010,
      ST_ITER   = 6'b000100,
      ST_FOLD   = 6'b001000,
      ST_MULT   = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

   typedef struct packed {
      logic take;
      logic setup;
      logic iter;
      logic fold;
      logic mult;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

   function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
      logic signed [ZW-1:0] r;
      begin
         case (i)
            5'd0:  r = 34'sd843314857;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043837;
            5'd3:  r = 34'sd133525159;
            5'd4:  r = 34'sd67021687;
            5'd5:  r = 34'sd33543516;
            5'd6:  r = 34'sd16775851;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194283;
            5'd9:  r = 34'sd2097149;
            default: r = ZW'(34'sd1073741824 >>> i);
         endcase
         return r;
      end
   endfunction

endpackage

// File: rtl/core/lhs_if.sv
// Valid/ready channel interfaces for requests and responses.
interface lhs_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] robot_x;
   logic signed [23:0] robot_y;
   logic signed [15:0] robot_heading;
   logic signed [23:0] point_x;
   logic signed [23:0] point_y;
   logic               last_point;
   modport source (output valid, robot_x, robot_y, robot_heading, point_x, point_y,
                   last_point, input ready);
   modport sink (input valid, robot_x, robot_y, robot_heading, point_x, point_y,
                 last_point, output ready);
endinterface

interface lhs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [19:0] steer_rate;
   logic signed [23:0] goal_x;
   logic signed [23:0] goal_y;
   logic               used_fallback;
   modport source (output valid, steer_rate, goal_x, goal_y, used_fallback, input ready);
   modport sink (input valid, steer_rate, goal_x, goal_y, used_fallback, output ready);
endinterface

// File: rtl/core/lhs_ctrl.sv
// Controller state machine sequencing search, CORDIC and output.
module lhs_ctrl import lhs_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   input  status_type status,
   output cmd_type    cmd
);
   localparam int IW = $clog2(CORDIC_STEPS + 1);
   state_type state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      in_ready = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.take = 1'b1;
               if (status.last) state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            cnt_in = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            cmd.iter = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IW'(CORDIC_STEPS - 1)) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               cmd.clear = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule

// File: rtl/core/lhs_dp.sv
// Datapath: lookahead search, CORDIC atan2, angle fold and gain multiply.
module lhs_dp import lhs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [15:0]        lookahead,
   input  logic [15:0]        gain,
   input  logic signed [23:0] robot_x,
   input  logic signed [23:0] robot_y,
   input  logic signed [15:0] robot_heading,
   input  logic signed [23:0] point_x,
   input  logic signed [23:0] point_y,
   input  logic               last_point,
   output logic signed [19:0] steer_rate,
   output logic signed [23:0] goal_x,
   output logic signed [23:0] goal_y,
   output logic               used_fallback
);
   logic [DIST_W-1:0] best_d_ff;
   logic signed [23:0] best_x_ff, best_y_ff;
   logic found_ff;
   logic signed [23:0] rx_ff, ry_ff, gx_ff, gy_ff;
   logic signed [15:0] hd_ff;
   logic fb_ff;
   logic signed [CW-1:0] x_ff, y_ff;
   logic signed [ZW-1:0] z_ff;
   logic [4:0] i_ff;
   logic zero_ff;
   logic signed [18:0] err_ff;
   logic signed [19:0] steer_ff;

   logic signed [24:0] dx, dy;
   logic signed [49:0] dx2, dy2;
   logic [DIST_W-1:0] d2;
   logic [31:0] l2;
   logic qual;

   assign status.last = last_point;
   assign dx = 25'(point_x) - 25'(robot_x);
   assign dy = 25'(point_y) - 25'(robot_y);
   assign dx2 = 50'(dx) * 50'(dx);
   assign dy2 = 50'(dy) * 50'(dy);
   assign d2 = DIST_W'(unsigned'(dx2)) + DIST_W'(unsigned'(dy2));
   assign l2 = lookahead * lookahead;
   assign qual = (d2 >= DIST_W'(l2)) && (!found_ff || d2 < best_d_ff);

   // goal vector for CORDIC setup
   logic signed [24:0] gdx, gdy;
   logic signed [CW-1:0] sx, sy, xs, ys;
   assign gdx = 25'(gx_ff) - 25'(rx_ff);
   assign gdy = 25'(gy_ff) - 25'(ry_ff);
   assign sx = CW'(gdx) <<< 6;
   assign sy = CW'(gdy) <<< 6;
   assign xs = x_ff >>> i_ff;
   assign ys = y_ff >>> i_ff;

   // fold: round bearing, subtract heading, wrap
   logic signed [ZW-1:0] zr;
   logic signed [18:0] bear, e0, e1;
   assign zr = (z_ff + ZW'(65536)) >>> 17;
   assign bear = zero_ff ? 19'sd0 : 19'(zr);
   assign e0 = bear - 19'(hd_ff);
   always_comb begin
      e1 = e0;
      if (e1 < 0) e1 = e1 + TWO_PI_Q13;
      if (e1 >= TWO_PI_Q13) e1 = e1 - TWO_PI_Q13;
      if (e1 >= PI_Q13) e1 = e1 - TWO_PI_Q13;
   end

   logic signed [35:0] prod, ps;
   assign prod = $signed({1'b0, gain}) * 36'(err_ff);
   assign ps = (prod + 36'sd2048) >>> 12;

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff  <= 1'b0;
         best_d_ff <= '1;
         best_x_ff <= '0;
         best_y_ff <= '0;
      end else if (cmd.clear) begin
         found_ff  <= 1'b0;
         best_d_ff <= '1;
         best_x_ff <= '0;
         best_y_ff <= '0;
      end else if (cmd.take && qual) begin
         found_ff  <= 1'b1;
         best_d_ff <= d2;
         best_x_ff <= point_x;
         best_y_ff <= point_y;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && last_point) begin
         rx_ff <= robot_x;
         ry_ff <= robot_y;
         hd_ff <= robot_heading;
         if (found_ff || qual) begin
            gx_ff <= qual ? point_x : best_x_ff;
            gy_ff <= qual ? point_y : best_y_ff;
            fb_ff <= 1'b0;
         end else begin
            gx_ff <= point_x;
            gy_ff <= point_y;
            fb_ff <= 1'b1;
         end
      end
      if (cmd.setup) begin
         i_ff <= '0;
         zero_ff <= (gdx == 0) && (gdy == 0);
         if (gdx < 0) begin
            x_ff <= -sx;
            y_ff <= -sy;
            z_ff <= (gdy >= 0) ? PI_Q30 : -PI_Q30;
         end else begin
            x_ff <= sx;
            y_ff <= sy;
            z_ff <= '0;
         end
      end
      if (cmd.iter) begin
         i_ff <= i_ff + 1'b1;
         if (y_ff > 0) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + atan_q30(i_ff);
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - atan_q30(i_ff);
         end
      end
      if (cmd.fold) err_ff <= e1;
      if (cmd.mult) begin
         if (ps > 36'sd524287) steer_ff <= 20'sd524287;
         else if (ps < -36'sd524288) steer_ff <= -20'sd524288;
         else steer_ff <= 20'(ps);
      end
   end

   assign steer_rate = steer_ff;
   assign goal_x = gx_ff;
   assign goal_y = gy_ff;
   assign used_fallback = fb_ff;
endmodule

// File: rtl/core/lookahead_heading_steer.sv
// Top level of the lookahead heading steer block.
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/ready    | robot pose, path point, last flag
//  rsp     | out | rsp_valid/ready    | steer rate, goal, fallback flag
//  csr     | in  | APB write/read     | lookahead distance, yaw gain
// A non-last point is taken in the idle state. A last point passes through the setup,
// CORDIC iteration, fold and multiply states before the response is offered.
// Reset is synchronous; it restores register defaults and clears the search.
// The request side stalls while a response waits to be taken.
module lookahead_heading_steer import lhs_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   lhs_req_if.sink     req,
   lhs_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [15:0] look_ff, gain_ff;
   cmd_type    cmd;
   status_type status;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         look_ff <= 16'd1000;
         gain_ff <= 16'd8192;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == 1'(ADDR_LOOKAHEAD)) look_ff <= csr_pwdata[15:0];
         else gain_ff <= csr_pwdata[15:0];
      end
   end
   assign csr_prdata = {16'd0, (csr_paddr[2] == 1'(ADDR_GAIN)) ? gain_ff : look_ff};

   lhs_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .status, .cmd
   );

   lhs_dp u_dp (
      .clock, .reset, .cmd, .status,
      .lookahead(look_ff), .gain(gain_ff),
      .robot_x(req.robot_x), .robot_y(req.robot_y), .robot_heading(req.robot_heading),
      .point_x(req.point_x), .point_y(req.point_y), .last_point(req.last_point),
      .steer_rate(rsp.steer_rate), .goal_x(rsp.goal_x), .goal_y(rsp.goal_y),
      .used_fallback(rsp.used_fallback)
   );
endmodule

// File: rtl/core/lhs_checker.sv
// Port-level checker for the lookahead heading steer block.
module lhs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last_point,
   input logic rsp_valid,
   input logic rsp_ready
);
   a_no_take_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");
   a_nonlast_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_last_point) |=> !rsp_valid)
      else $error("response after non-last point");
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_point) |=> !req_ready)
      else $error("request accepted during steering computation");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");
endmodule

bind lookahead_heading_steer lhs_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready), .req_last_point(req.last_point),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready)
);
